// ----- design/ccbs_pkg.sv -----
// ccbs_pkg: shared constants and types for the code column bit slicer.
// Holds field widths, parameter defaults and the segment descriptor that
// the front part hands to the back part. No dependencies.
`default_nettype none

package ccbs_pkg;

	localparam int WORD_BITS         = 64;  // bits in one slice word
	localparam int CODE_BITS         = 32;  // width of the code input
	localparam int CFG_W             = 6;   // width of the code length register
	localparam int LEN_W             = 7;   // holds a length up to 64
	localparam int SLICE_IDX_W       = 5;
	localparam int SEG_W             = 25;
	localparam int DEF_MAX_CODE_BITS = 32;
	localparam int DEF_SEGMENT_CODES = 64;

	localparam logic [CFG_W-1:0] CODE_LENGTH_RESET = CFG_W'(32);

	// Describes one closed segment waiting to be emitted.
	typedef struct packed {
		logic [LEN_W-1:0] len;  // slices to emit
		logic [SEG_W-1:0] seg;  // segment index
		logic             eoc;  // segment closed by the last code
	} seg_desc_t;

endpackage

`default_nettype wire

// ----- design/ccbs_front.sv -----
// ccbs_front: accepts codes and gathers their bits into the open segment's
// slice store; hands each closed segment to the back part.
// Depends on ccbs_pkg.
`default_nettype none

module ccbs_front import ccbs_pkg::*; #(
	parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
	parameter int SEGMENT_CODES = DEF_SEGMENT_CODES
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic [CFG_W-1:0]                          code_length,
	input  wire logic                                      push,
	output      logic                                      full,
	input  wire logic [CODE_BITS-1:0]                      code_value,
	input  wire logic                                      last_code,
	output      logic                                      hand_valid,
	input  wire logic                                      hand_ready,
	output      seg_desc_t                                 hand_desc,
	output      logic [MAX_CODE_BITS-1:0][WORD_BITS-1:0]   hand_data
);

	localparam int POS_W = $clog2(SEGMENT_CODES);
	localparam logic [WORD_BITS-1:0] TOP_BIT = {1'b1, {(WORD_BITS-1){1'b0}}};
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_BITS);

	logic [MAX_CODE_BITS-1:0][WORD_BITS-1:0] store_q;
	logic [MAX_CODE_BITS-1:0][WORD_BITS-1:0] merged;
	logic [POS_W-1:0]                        pos_q;
	logic [SEG_W-1:0]                        seg_q;
	logic                                    pend_q;
	seg_desc_t                               pend_desc_q;
	seg_desc_t                               new_desc;

	logic [LEN_W-1:0]             cfg_ext;
	logic [LEN_W-1:0]             eff_len;
	logic [MAX_CODE_BITS+31:0]    code_ext;
	logic [MAX_CODE_BITS+31:0]    code_sh;
	logic [MAX_CODE_BITS-1:0]     aligned;
	logic [WORD_BITS-1:0]         colmask;
	logic                         accept;
	logic                         close;
	logic                         xfer;

	// clamp the length: zero acts as one, above the store depth as the depth
	always_comb begin
		cfg_ext = LEN_W'(code_length);
		if (cfg_ext == '0) begin
			eff_len = LEN_W'(1);
		end else if (cfg_ext > MAX_LEN) begin
			eff_len = MAX_LEN;
		end else begin
			eff_len = cfg_ext;
		end
	end

	// move code bit len-1 to the top of an aligned word; slice k reads bit W-1-k
	assign code_ext = {{MAX_CODE_BITS{1'b0}}, code_value};
	assign code_sh  = code_ext << (MAX_LEN - eff_len);
	assign aligned  = code_sh[MAX_CODE_BITS-1:0];
	assign colmask  = TOP_BIT >> pos_q;

	always_comb begin
		for (int k = 0; k < MAX_CODE_BITS; k++) begin
			if (aligned[MAX_CODE_BITS-1-k] && (LEN_W'(k) < eff_len)) begin
				merged[k] = store_q[k] | colmask;
			end else begin
				merged[k] = store_q[k];
			end
		end
	end

	assign full   = pend_q;
	assign accept = push && !full;
	assign close  = accept && (last_code || (pos_q == POS_W'(SEGMENT_CODES - 1)));
	assign xfer   = (close || pend_q) && hand_ready;

	always_comb begin
		new_desc.len = eff_len;
		new_desc.seg = seg_q;
		new_desc.eoc = last_code;
	end

	assign hand_valid = close || pend_q;
	assign hand_desc  = pend_q ? pend_desc_q : new_desc;
	assign hand_data  = pend_q ? store_q : merged;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q     <= '0;
			pos_q       <= '0;
			seg_q       <= '0;
			pend_q      <= 1'b0;
			pend_desc_q <= '0;
		end else begin
			if (accept) begin
				if (close) begin
					pos_q       <= '0;
					seg_q       <= last_code ? '0 : seg_q + 1'b1;
					pend_desc_q <= new_desc;
					// hold the closed segment when the back part is still busy
					store_q     <= xfer ? '0 : merged;
					pend_q      <= !xfer;
				end else begin
					pos_q   <= pos_q + 1'b1;
					store_q <= merged;
				end
			end else if (xfer) begin
				store_q <= '0;
				pend_q  <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/ccbs_back.sv -----
// ccbs_back: one-segment buffer and emitter; sends one slice word a cycle while the output
// slot is free, through an output register with a queue-style empty/pop handshake.
// Depends on ccbs_pkg.
`default_nettype none

module ccbs_back import ccbs_pkg::*; #(
	parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      hand_valid,
	output      logic                                      hand_ready,
	input  wire seg_desc_t                                 hand_desc,
	input  wire logic [MAX_CODE_BITS-1:0][WORD_BITS-1:0]   hand_data,
	output      logic                                      empty,
	input  wire logic                                      pop,
	output      logic [SLICE_IDX_W-1:0]                    slice_index,
	output      logic [SEG_W-1:0]                          segment_index,
	output      logic [WORD_BITS-1:0]                      slice_word,
	output      logic                                      last_of_run,
	output      logic                                      end_of_column
);

	localparam int KW = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;

	logic [MAX_CODE_BITS-1:0][WORD_BITS-1:0] buf_q;
	seg_desc_t                               desc_q;
	logic                                    busy_q;
	logic [KW-1:0]                           k_q;
	logic                                    ovalid_q;
	logic [SLICE_IDX_W-1:0]                  slice_index_q;
	logic [SEG_W-1:0]                        segment_index_q;
	logic [WORD_BITS-1:0]                    slice_word_q;
	logic                                    last_of_run_q;
	logic                                    end_of_column_q;

	logic                   slot_free;
	logic                   issue;
	logic                   fin;
	logic                   load;
	logic [KW+SLICE_IDX_W-1:0] k_ext;

	assign slot_free  = !ovalid_q || pop;
	assign issue      = busy_q && slot_free;
	assign fin        = issue && ((LEN_W'(k_q) + LEN_W'(1)) == desc_q.len);
	assign hand_ready = !busy_q || fin;
	assign load       = hand_valid && hand_ready;
	assign k_ext      = {{SLICE_IDX_W{1'b0}}, k_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (issue) begin
				k_q <= k_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q  <= hand_data;
			desc_q <= hand_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else begin
			if (issue) begin
				ovalid_q <= 1'b1;
			end else if (pop) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			slice_index_q   <= k_ext[SLICE_IDX_W-1:0];
			segment_index_q <= desc_q.seg;
			slice_word_q    <= buf_q[k_q];
			last_of_run_q   <= (LEN_W'(k_q) + LEN_W'(1)) == desc_q.len;
			end_of_column_q <= desc_q.eoc;
		end
	end

	assign empty         = !ovalid_q;
	assign slice_index   = slice_index_q;
	assign segment_index = segment_index_q;
	assign slice_word    = slice_word_q;
	assign last_of_run   = last_of_run_q;
	assign end_of_column = end_of_column_q;

endmodule

`default_nettype wire

// ----- design/code_column_bit_slicer.sv -----
// code_column_bit_slicer: one code per cycle in while full is low; a closing code's segment
// passes through the emitter's segment buffer and output register, then one word per cycle
// while popped, the closing code's code_length words per segment (1..MAX_CODE_BITS).
// Throughput: one code per cycle while full is low; full rises only when a segment closes
// while the emitter still drains the segment before, at one word a cycle while popped.
// Reset (arst_n low, asynchronous): slice store, position and segment count clear,
// no results pending, code_length returns to 32.
`default_nettype none

module code_column_bit_slicer import ccbs_pkg::*; #(
	parameter int MAX_CODE_BITS = DEF_MAX_CODE_BITS,
	parameter int SEGMENT_CODES = DEF_SEGMENT_CODES
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	// configuration: bits per code
	input  wire logic                     cfg_we,
	input  wire logic [CFG_W-1:0]         cfg_wdata,
	// code requests
	input  wire logic                     push,
	output      logic                     full,
	input  wire logic [CODE_BITS-1:0]     code_value,
	input  wire logic                     last_code,
	// slice word requests
	output      logic                     empty,
	input  wire logic                     pop,
	output      logic [SLICE_IDX_W-1:0]   slice_index,
	output      logic [SEG_W-1:0]         segment_index,
	output      logic [WORD_BITS-1:0]     slice_word,
	output      logic                     last_of_run,
	output      logic                     end_of_column
);

	logic [CFG_W-1:0]                        code_length_q;
	logic                                    hand_valid;
	logic                                    hand_ready;
	seg_desc_t                               hand_desc;
	logic [MAX_CODE_BITS-1:0][WORD_BITS-1:0] hand_data;

	// Hold the code length; it may change between codes of one segment, each
	// code is sliced with the length in force when it arrives.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q <= CODE_LENGTH_RESET;
		end else if (cfg_we) begin
			code_length_q <= cfg_wdata;
		end
	end

	// Front: gather bits of each accepted code into the open segment and
	// close it after the last position or on the column's last code. A closed
	// segment waits here, with full high, while the back part is busy.
	ccbs_front #(
		.MAX_CODE_BITS (MAX_CODE_BITS),
		.SEGMENT_CODES (SEGMENT_CODES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.code_length (code_length_q),
		.push        (push),
		.full        (full),
		.code_value  (code_value),
		.last_code   (last_code),
		.hand_valid  (hand_valid),
		.hand_ready  (hand_ready),
		.hand_desc   (hand_desc),
		.hand_data   (hand_data)
	);

	// Back: buffer one closed segment and advance through its slices, most
	// significant code bit first, one word per free output slot. It takes the
	// next segment in the same cycle that it issues the final word.
	ccbs_back #(
		.MAX_CODE_BITS (MAX_CODE_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.hand_valid    (hand_valid),
		.hand_ready    (hand_ready),
		.hand_desc     (hand_desc),
		.hand_data     (hand_data),
		.empty         (empty),
		.pop           (pop),
		.slice_index   (slice_index),
		.segment_index (segment_index),
		.slice_word    (slice_word),
		.last_of_run   (last_of_run),
		.end_of_column (end_of_column)
	);

endmodule

`default_nettype wire
